// ===== hw/rtl/pdc_pkg.sv =====
package pdc_pkg;

  localparam logic [7:0]  START_BYTE      = 8'h55;
  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd48;

  typedef enum logic [4:0] {
    ST_SOH1,
    ST_SOH2,
    ST_CK1,
    ST_CK2,
    ST_CHUNK1,
    ST_CHUNK2,
    ST_CNT1,
    ST_CNT2,
    ST_SEQ1,
    ST_SEQ2,
    ST_TYPE,
    ST_TS1,
    ST_TS2,
    ST_TS3,
    ST_TS4,
    ST_LEN,
    ST_PAYLOAD
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_OK,
    KIND_CRC_ERR,
    KIND_INCOMPLETE
  } kind_t;

  // All results caused by one input byte share the captured header fields.
  typedef struct packed {
    kind_t       kind0;
    kind_t       kind1;
    logic        two;
    logic [7:0]  data_byte;
    logic [15:0] chunk_num;
    logic [15:0] chunk_count;
    logic [15:0] host_seq;
    logic [7:0]  pkt_type;
    logic [31:0] timestamp;
    logic [7:0]  pay_len;
    logic [15:0] received_checksum;
  } frame_entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] chunk_num;
    logic [15:0] chunk_count;
    logic [15:0] host_seq;
    logic [7:0]  pkt_type;
    logic [31:0] timestamp;
    logic [7:0]  pay_len;
    logic [15:0] received_checksum;
    logic        last;
  } result_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (x[15]) begin
        x = {x[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[14:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

// ===== hw/rtl/pdc_in_if.sv =====
interface pdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_transfer;

  modport source (output valid, output rx_byte, output end_of_transfer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_transfer, output ready);
endinterface

// ===== hw/rtl/pdc_out_if.sv =====
interface pdc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] chunk_num;
  logic [15:0] chunk_count;
  logic [15:0] host_seq;
  logic [7:0]  pkt_type;
  logic [31:0] timestamp;
  logic [7:0]  pay_len;
  logic [15:0] received_checksum;
  logic        last;

  modport source (
    output valid, output kind, output data_byte, output chunk_num,
    output chunk_count, output host_seq, output pkt_type, output timestamp,
    output pay_len, output received_checksum, output last, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input chunk_num,
    input chunk_count, input host_seq, input pkt_type, input timestamp,
    input pay_len, input received_checksum, input last, output ready
  );
endinterface

// ===== hw/rtl/pdc_res_queue.sv =====
// Two-entry queue of per-byte result groups; each group unrolls into one or
// two result transactions.
module pdc_res_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pdc_pkg::frame_entry_t push_entry,
  output logic                  full,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pdc_pkg::result_t      res
);

  pdc_pkg::frame_entry_t head_r, head_nxt;
  pdc_pkg::frame_entry_t tail_r, tail_nxt;
  logic head_v_r, head_v_nxt;
  logic tail_v_r, tail_v_nxt;
  logic sub_r, sub_nxt;
  logic pop_res;
  logic head_done;

  assign full      = tail_v_r;
  assign res_valid = head_v_r;
  assign pop_res   = head_v_r && res_ready;
  assign head_done = pop_res && (!head_r.two || sub_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    head_v_nxt = head_v_r;
    tail_v_nxt = tail_v_r;
    sub_nxt    = sub_r;
    if (pop_res) begin
      sub_nxt = !head_done;
    end
    if (head_done) begin
      if (tail_v_r) begin
        head_nxt   = tail_r;
        tail_v_nxt = push;
        tail_nxt   = push_entry;
      end else begin
        head_v_nxt = push;
        head_nxt   = push_entry;
      end
    end else if (!head_v_r) begin
      head_v_nxt = push;
      head_nxt   = push_entry;
    end else if (push) begin
      tail_v_nxt = 1'b1;
      tail_nxt   = push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
      sub_r    <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
      sub_r    <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  always_comb begin
    res.kind              = sub_r ? head_r.kind1 : head_r.kind0;
    res.data_byte         = sub_r ? 8'h00 : head_r.data_byte;
    res.chunk_num         = head_r.chunk_num;
    res.chunk_count       = head_r.chunk_count;
    res.host_seq          = head_r.host_seq;
    res.pkt_type          = head_r.pkt_type;
    res.timestamp         = head_r.timestamp;
    res.pay_len           = head_r.pay_len;
    res.received_checksum = head_r.received_checksum;
    res.last              = !head_r.two || sub_r;
  end

endmodule

// ===== hw/rtl/packet_deframer_crc16.sv =====
// Throughput: one byte per cycle while the result queue is not full; the input
// stalls (in_ch.ready low) when it is. A byte that causes two results (payload byte
// plus verdict, or payload byte plus incomplete) fills one queue entry that unrolls
// into two output transactions. Parser state and CRC are updated a whole byte at a time.
// Reset (synchronous, rst_n low): parser waits for a start byte, captured fields
// and CRC clear, max_payload returns to 48, result queue empties.
module packet_deframer_crc16 (
  input  logic             clk,
  input  logic             rst_n,
  pdc_in_if.sink           in_ch,
  pdc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);

  pdc_pkg::parse_state_t state_r, state_nxt;
  logic [15:0] held_checksum_r, held_checksum_nxt;
  logic [15:0] chunk_r, chunk_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  max_payload_r;

  logic        accept;
  logic        q_full;
  logic        is_data;
  logic        verdict;
  logic        incomplete;
  logic [7:0]  b;
  pdc_pkg::kind_t        verdict_kind;
  pdc_pkg::frame_entry_t entry;
  logic                  push;
  pdc_pkg::result_t      res;

  assign b           = in_ch.rx_byte;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // next state
  always_comb begin
    state_nxt         = state_r;
    held_checksum_nxt = held_checksum_r;
    chunk_nxt         = chunk_r;
    total_nxt         = total_r;
    seq_nxt           = seq_r;
    type_nxt          = type_r;
    stamp_nxt         = stamp_r;
    length_nxt        = length_r;
    bytes_left_nxt    = bytes_left_r;
    crc_nxt           = crc_r;
    is_data           = 1'b0;
    verdict           = 1'b0;
    incomplete        = 1'b0;
    if (accept) begin
      case (state_r)
        pdc_pkg::ST_SOH1: begin
          bytes_left_nxt = 8'h00;
          if (b == pdc_pkg::START_BYTE) state_nxt = pdc_pkg::ST_SOH2;
        end
        pdc_pkg::ST_SOH2: begin
          state_nxt = (b == pdc_pkg::START_BYTE) ? pdc_pkg::ST_CK1 : pdc_pkg::ST_SOH1;
        end
        pdc_pkg::ST_CK1: begin
          held_checksum_nxt = {8'h00, b};
          state_nxt         = pdc_pkg::ST_CK2;
        end
        pdc_pkg::ST_CK2: begin
          held_checksum_nxt = {held_checksum_r[7:0], b};
          state_nxt         = pdc_pkg::ST_CHUNK1;
        end
        pdc_pkg::ST_CHUNK1: begin
          chunk_nxt = {8'h00, b};
          state_nxt = pdc_pkg::ST_CHUNK2;
        end
        pdc_pkg::ST_CHUNK2: begin
          chunk_nxt = {chunk_r[7:0], b};
          state_nxt = pdc_pkg::ST_CNT1;
        end
        pdc_pkg::ST_CNT1: begin
          total_nxt = {8'h00, b};
          state_nxt = pdc_pkg::ST_CNT2;
        end
        pdc_pkg::ST_CNT2: begin
          total_nxt = {total_r[7:0], b};
          state_nxt = pdc_pkg::ST_SEQ1;
        end
        pdc_pkg::ST_SEQ1: begin
          seq_nxt   = {8'h00, b};
          state_nxt = pdc_pkg::ST_SEQ2;
        end
        pdc_pkg::ST_SEQ2: begin
          seq_nxt   = {seq_r[7:0], b};
          state_nxt = pdc_pkg::ST_TYPE;
        end
        pdc_pkg::ST_TYPE: begin
          type_nxt  = b;
          state_nxt = pdc_pkg::ST_TS1;
        end
        pdc_pkg::ST_TS1: begin
          stamp_nxt = {24'h000000, b};
          state_nxt = pdc_pkg::ST_TS2;
        end
        pdc_pkg::ST_TS2: begin
          stamp_nxt = {stamp_r[23:0], b};
          state_nxt = pdc_pkg::ST_TS3;
        end
        pdc_pkg::ST_TS3: begin
          stamp_nxt = {stamp_r[23:0], b};
          state_nxt = pdc_pkg::ST_TS4;
        end
        pdc_pkg::ST_TS4: begin
          stamp_nxt = {stamp_r[23:0], b};
          state_nxt = pdc_pkg::ST_LEN;
        end
        pdc_pkg::ST_LEN: begin
          length_nxt     = b;
          bytes_left_nxt = b;
          if (b > max_payload_r) begin
            state_nxt = pdc_pkg::ST_SOH1;   // oversize: drop silently
          end else if (b == 8'h00) begin
            verdict = 1'b1;
          end else begin
            state_nxt = pdc_pkg::ST_PAYLOAD;
          end
        end
        pdc_pkg::ST_PAYLOAD: begin
          is_data        = 1'b1;
          bytes_left_nxt = bytes_left_r - 8'd1;
          if (bytes_left_nxt == 8'h00) verdict = 1'b1;
        end
        default: begin
          state_nxt = pdc_pkg::ST_SOH1;
        end
      endcase

      // CRC restarts at the chunk number field
      crc_nxt = pdc_pkg::crc16_byte((state_r == pdc_pkg::ST_CHUNK1) ? 16'h0000 : crc_r, b);

      if (verdict) state_nxt = pdc_pkg::ST_SOH1;
      if (in_ch.end_of_transfer && state_nxt != pdc_pkg::ST_SOH1) begin
        incomplete = 1'b1;
        state_nxt  = pdc_pkg::ST_SOH1;
      end
    end
  end

  // result group for this byte
  always_comb begin
    verdict_kind = (crc_nxt == held_checksum_nxt) ? pdc_pkg::KIND_OK : pdc_pkg::KIND_CRC_ERR;
    push         = is_data || verdict || incomplete;

    if (is_data) begin
      entry.kind0 = pdc_pkg::KIND_DATA;
    end else if (verdict) begin
      entry.kind0 = verdict_kind;
    end else begin
      entry.kind0 = pdc_pkg::KIND_INCOMPLETE;
    end
    entry.kind1             = (is_data && verdict) ? verdict_kind : pdc_pkg::KIND_INCOMPLETE;
    entry.two               = is_data && (verdict || incomplete);
    entry.data_byte         = is_data ? b : 8'h00;
    entry.chunk_num         = chunk_nxt;
    entry.chunk_count       = total_nxt;
    entry.host_seq          = seq_nxt;
    entry.pkt_type          = type_nxt;
    entry.timestamp         = stamp_nxt;
    entry.pay_len           = length_nxt;
    entry.received_checksum = held_checksum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= pdc_pkg::ST_SOH1;
      held_checksum_r <= '0;
      chunk_r         <= '0;
      total_r         <= '0;
      seq_r           <= '0;
      type_r          <= '0;
      stamp_r         <= '0;
      length_r        <= '0;
      bytes_left_r    <= '0;
      crc_r           <= '0;
      max_payload_r   <= pdc_pkg::MAX_PAYLOAD_RST;
    end else begin
      state_r         <= state_nxt;
      held_checksum_r <= held_checksum_nxt;
      chunk_r         <= chunk_nxt;
      total_r         <= total_nxt;
      seq_r           <= seq_nxt;
      type_r          <= type_nxt;
      stamp_r         <= stamp_nxt;
      length_r        <= length_nxt;
      bytes_left_r    <= bytes_left_nxt;
      crc_r           <= crc_nxt;
      if (cfg_we) max_payload_r <= cfg_wdata;
    end
  end

  pdc_res_queue u_res_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (entry),
    .full       (q_full),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.kind              = res.kind;
  assign out_ch.data_byte         = res.data_byte;
  assign out_ch.chunk_num         = res.chunk_num;
  assign out_ch.chunk_count       = res.chunk_count;
  assign out_ch.host_seq          = res.host_seq;
  assign out_ch.pkt_type          = res.pkt_type;
  assign out_ch.timestamp         = res.timestamp;
  assign out_ch.pay_len           = res.pay_len;
  assign out_ch.received_checksum = res.received_checksum;
  assign out_ch.last              = res.last;

endmodule

// ===== dv/tb_packet_deframer_crc16.sv =====
module tb_packet_deframer_crc16;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_BYTES = 600;
  localparam int NO_CUT       = -1;
  // Header and payload fill modes for generated frames
  localparam int FILL_RANDOM  = 0;
  localparam int FILL_ZEROS   = 1;
  localparam int FILL_ONES    = 2;
  // Offset of the length byte; payload starts right after it
  localparam int LEN_OFFSET   = 15;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  pdc_in_if  in_ch ();
  pdc_out_if out_ch ();

  packet_deframer_crc16 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted deframer state
  pdc_pkg::parse_state_t fr_state;
  logic [15:0]  fr_check;
  logic [15:0]  fr_chunk;
  logic [15:0]  fr_total;
  logic [15:0]  fr_seq;
  logic [7:0]   fr_type;
  logic [31:0]  fr_stamp;
  logic [7:0]   fr_len;
  logic [7:0]   fr_left;
  logic [15:0]  fr_crc;
  logic [7:0]   payload_limit;

  pdc_pkg::result_t deframed_q[$];

  int errors;
  int cycles;
  int bytes_sent;
  int n_data, n_ok, n_crc_err, n_incomplete;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, deframed_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Bit-serial CRC-16/XMODEM
  function automatic logic [15:0] xmodem_crc_update(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    logic fb;
    v = c;
    for (int k = 7; k >= 0; k--) begin
      fb = v[15] ^ b[k];
      v = {v[14:0], 1'b0};
      if (fb) v = v ^ pdc_pkg::CRC_POLY;
    end
    return v;
  endfunction

  function automatic pdc_pkg::result_t capture(pdc_pkg::kind_t k, logic [7:0] d);
    pdc_pkg::result_t r;
    r.kind              = k;
    r.data_byte         = d;
    r.chunk_num         = fr_chunk;
    r.chunk_count       = fr_total;
    r.host_seq          = fr_seq;
    r.pkt_type          = fr_type;
    r.timestamp         = fr_stamp;
    r.pay_len           = fr_len;
    r.received_checksum = fr_check;
    r.last              = 1'b0;
    return r;
  endfunction

  task automatic reset_deframe_state();
    fr_state      = pdc_pkg::ST_SOH1;
    fr_check      = '0;
    fr_chunk      = '0;
    fr_total      = '0;
    fr_seq        = '0;
    fr_type       = '0;
    fr_stamp      = '0;
    fr_len        = '0;
    fr_left       = '0;
    fr_crc        = '0;
    payload_limit = pdc_pkg::MAX_PAYLOAD_RST;
  endtask

  task automatic deframe_step(logic [7:0] b, logic eot);
    pdc_pkg::result_t got[2];
    int n;
    bit verdict;
    n = 0;
    verdict = 1'b0;
    case (fr_state)
      pdc_pkg::ST_SOH1: begin
        fr_left = '0;
        if (b == pdc_pkg::START_BYTE) fr_state = pdc_pkg::ST_SOH2;
      end
      pdc_pkg::ST_SOH2: begin
        fr_state = (b == pdc_pkg::START_BYTE) ? pdc_pkg::ST_CK1 : pdc_pkg::ST_SOH1;
      end
      pdc_pkg::ST_CK1: begin
        fr_check = {8'h00, b};
        fr_state = pdc_pkg::ST_CK2;
      end
      pdc_pkg::ST_CK2: begin
        fr_check = {fr_check[7:0], b};
        fr_state = pdc_pkg::ST_CHUNK1;
      end
      pdc_pkg::ST_CHUNK1: begin
        fr_crc   = '0;
        fr_chunk = {8'h00, b};
        fr_state = pdc_pkg::ST_CHUNK2;
      end
      pdc_pkg::ST_CHUNK2: begin
        fr_chunk = {fr_chunk[7:0], b};
        fr_state = pdc_pkg::ST_CNT1;
      end
      pdc_pkg::ST_CNT1: begin
        fr_total = {8'h00, b};
        fr_state = pdc_pkg::ST_CNT2;
      end
      pdc_pkg::ST_CNT2: begin
        fr_total = {fr_total[7:0], b};
        fr_state = pdc_pkg::ST_SEQ1;
      end
      pdc_pkg::ST_SEQ1: begin
        fr_seq   = {8'h00, b};
        fr_state = pdc_pkg::ST_SEQ2;
      end
      pdc_pkg::ST_SEQ2: begin
        fr_seq   = {fr_seq[7:0], b};
        fr_state = pdc_pkg::ST_TYPE;
      end
      pdc_pkg::ST_TYPE: begin
        fr_type  = b;
        fr_state = pdc_pkg::ST_TS1;
      end
      pdc_pkg::ST_TS1: begin
        fr_stamp = {24'h0, b};
        fr_state = pdc_pkg::ST_TS2;
      end
      pdc_pkg::ST_TS2, pdc_pkg::ST_TS3, pdc_pkg::ST_TS4: begin
        fr_stamp = {fr_stamp[23:0], b};
        fr_state = pdc_pkg::parse_state_t'(fr_state + 5'd1);
      end
      pdc_pkg::ST_LEN: begin
        fr_len  = b;
        fr_left = b;
        if (b > payload_limit) fr_state = pdc_pkg::ST_SOH1;
        else if (b == 8'd0) verdict = 1'b1;
        else fr_state = pdc_pkg::ST_PAYLOAD;
      end
      pdc_pkg::ST_PAYLOAD: begin
        got[n] = capture(pdc_pkg::KIND_DATA, b);
        n++;
        fr_left = fr_left - 8'd1;
        if (fr_left == 8'd0) verdict = 1'b1;
      end
      default: fr_state = pdc_pkg::ST_SOH1;
    endcase
    fr_crc = xmodem_crc_update(fr_crc, b);
    if (verdict) begin
      got[n] = capture((fr_crc == fr_check) ? pdc_pkg::KIND_OK : pdc_pkg::KIND_CRC_ERR,
                       8'h00);
      n++;
      fr_state = pdc_pkg::ST_SOH1;
    end
    // end of transfer with a frame still open
    if (eot && fr_state != pdc_pkg::ST_SOH1) begin
      fr_state = pdc_pkg::ST_SOH1;
      got[n] = capture(pdc_pkg::KIND_INCOMPLETE, 8'h00);
      n++;
    end
    for (int i = 0; i < n; i++) begin
      got[i].last = (i == n - 1);
      deframed_q.push_back(got[i]);
    end
  endtask

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
      errors++;
    end
  endtask

  task automatic check_result();
    pdc_pkg::result_t e;
    if (deframed_q.size() == 0) begin
      $error("unexpected result transaction: kind %0d", out_ch.kind);
      errors++;
    end else begin
      e = deframed_q.pop_front();
      check_field("kind", 32'(e.kind), 32'(out_ch.kind));
      check_field("data_byte", 32'(e.data_byte), 32'(out_ch.data_byte));
      check_field("chunk_num", 32'(e.chunk_num), 32'(out_ch.chunk_num));
      check_field("chunk_count", 32'(e.chunk_count), 32'(out_ch.chunk_count));
      check_field("host_seq", 32'(e.host_seq), 32'(out_ch.host_seq));
      check_field("pkt_type", 32'(e.pkt_type), 32'(out_ch.pkt_type));
      check_field("timestamp", e.timestamp, out_ch.timestamp);
      check_field("pay_len", 32'(e.pay_len), 32'(out_ch.pay_len));
      check_field("received_checksum", 32'(e.received_checksum),
                  32'(out_ch.received_checksum));
      check_field("last", 32'(e.last), 32'(out_ch.last));
      case (e.kind)
        pdc_pkg::KIND_DATA:    n_data++;
        pdc_pkg::KIND_OK:      n_ok++;
        pdc_pkg::KIND_CRC_ERR: n_crc_err++;
        default:               n_incomplete++;
      endcase
    end
  endtask

  // Predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_deframe_state();
    end else begin
      if (cfg_we) payload_limit = cfg_wdata;
      if (in_ch.valid && in_ch.ready) deframe_step(in_ch.rx_byte, in_ch.end_of_transfer);
      if (out_ch.valid && out_ch.ready) check_result();
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side backpressure
  initial begin
    int run;
    int stall;
    out_ch.ready = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (run > 0) begin
        run--;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          run = stall - 1;
        end else begin
          out_ch.ready <= 1'b1;
          run = $urandom_range(0, 7);
        end
      end
    end
  end

  // Returns right after the accepting edge; valid stays up until the next drive
  task automatic send_byte(logic [7:0] b, logic eot);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.rx_byte         <= b;
    in_ch.end_of_transfer <= eot;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (deframed_q.size() != 0) @(negedge clk);
    // bytes with no result may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(logic [7:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_field(int bits, int fill);
    logic [31:0] mask;
    mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
    if (fill == FILL_ZEROS) return '0;
    if (fill == FILL_ONES) return mask;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  // Builds a frame with a matching checksum unless corrupt is set. With cut, only
  // the first cut bytes go out and the last of them ends the transfer.
  task automatic send_frame(int len, int fill, bit corrupt, int cut, bit eot_last);
    logic [7:0]  fb[$];
    logic [95:0] hdr;
    logic [15:0] chunk, total, seq;
    logic [7:0]  ptype, pbyte;
    logic [31:0] ts;
    logic [15:0] c;
    int stop;
    bit trunc;
    chunk = 16'(pick_field(16, fill));
    total = 16'(pick_field(16, fill));
    seq   = 16'(pick_field(16, fill));
    ptype = 8'(pick_field(8, fill));
    ts    = pick_field(32, fill);
    hdr   = {chunk, total, seq, ptype, ts, 8'(len)};
    for (int i = 11; i >= 0; i--) fb.push_back(hdr[i*8 +: 8]);
    for (int i = 0; i < len; i++) begin
      pbyte = 8'(pick_field(8, fill));
      if (fill == FILL_RANDOM && $urandom_range(0, 9) == 0) pbyte = pdc_pkg::START_BYTE;
      fb.push_back(pbyte);
    end
    c = '0;
    foreach (fb[i]) c = xmodem_crc_update(c, fb[i]);
    if (corrupt) c = c ^ (16'd1 << $urandom_range(0, 15));
    fb.push_front(c[7:0]);
    fb.push_front(c[15:8]);
    fb.push_front(pdc_pkg::START_BYTE);
    fb.push_front(pdc_pkg::START_BYTE);
    stop  = (cut != NO_CUT && cut < fb.size()) ? cut : fb.size();
    trunc = (stop < fb.size());
    for (int i = 0; i < stop; i++)
      send_byte(fb[i], (i == stop - 1) && (trunc || eot_last));
  endtask

  task automatic test_directed_frames();
    // reset value of the limit still in force here
    send_frame(0, FILL_ZEROS, 1'b0, NO_CUT, 1'b0);
    send_frame(1, FILL_ONES, 1'b0, NO_CUT, 1'b0);
    send_frame(48, FILL_RANDOM, 1'b0, NO_CUT, 1'b0);
    send_frame(49, FILL_ZEROS, 1'b0, NO_CUT, 1'b0);
    send_frame(49, FILL_RANDOM, 1'b0, LEN_OFFSET + 1, 1'b0);
    send_frame(5, FILL_RANDOM, 1'b1, NO_CUT, 1'b0);
    send_frame(0, FILL_ONES, 1'b1, NO_CUT, 1'b0);
    // bad second start byte
    send_byte(pdc_pkg::START_BYTE, 1'b0);
    send_byte(8'h54, 1'b0);
    send_frame(2, FILL_RANDOM, 1'b0, NO_CUT, 1'b0);
    // transfer ends with only the first start byte seen
    send_byte(pdc_pkg::START_BYTE, 1'b1);
    send_byte(8'hAA, 1'b1);
    send_frame(4, FILL_RANDOM, 1'b0, 2, 1'b0);
    send_frame(4, FILL_RANDOM, 1'b0, 3, 1'b0);
    send_frame(4, FILL_RANDOM, 1'b0, 10, 1'b0);
    send_frame(4, FILL_RANDOM, 1'b0, LEN_OFFSET + 1, 1'b0);
    send_frame(6, FILL_RANDOM, 1'b0, LEN_OFFSET + 3, 1'b0);
    send_frame(0, FILL_RANDOM, 1'b0, NO_CUT, 1'b1);
    send_frame(3, FILL_RANDOM, 1'b0, NO_CUT, 1'b1);
    send_frame(3, FILL_RANDOM, 1'b1, NO_CUT, 1'b1);
  endtask

  task automatic test_payload_limits();
    logic [7:0] limits[5];
    limits = '{8'd0, 8'd1, 8'd255, 8'h80, 8'($urandom_range(2, 40))};
    foreach (limits[i]) begin
      set_limit(limits[i]);
      send_frame(int'(limits[i]), FILL_RANDOM, 1'b0, NO_CUT, 1'b0);
      if (limits[i] != 8'd255) begin
        send_frame(int'(limits[i]) + 1, FILL_ZEROS, 1'b0, NO_CUT, 1'b0);
        send_frame(255, FILL_ONES, 1'b0, LEN_OFFSET + 1, 1'b0);
      end
      send_frame(0, FILL_RANDOM, 1'b0, NO_CUT, 1'b0);
    end
  endtask

  task automatic test_random_stream();
    int start;
    int limit;
    int cap;
    int len;
    int r;
    int nb;
    int next_toggle;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       limit = $urandom_range(8, 64);
        1:       limit = 255;
        default: limit = $urandom_range(1, 20);
      endcase
      set_limit(8'(limit));
      start = bytes_sent;
      next_toggle = bytes_sent + 150;
      while (bytes_sent - start < RANDOM_BYTES / 3) begin
        if (bytes_sent >= next_toggle) begin
          idle_on = ($urandom_range(0, 3) != 0);
          next_toggle = bytes_sent + $urandom_range(80, 200);
        end
        cap = (limit < 24) ? limit : 24;
        len = ($urandom_range(0, 19) == 0) ? limit : $urandom_range(0, cap);
        r = $urandom_range(0, 99);
        if (r < 62) begin
          send_frame(len, FILL_RANDOM, 1'b0, NO_CUT, $urandom_range(0, 4) == 0);
        end else if (r < 72) begin
          send_frame(len, FILL_RANDOM, 1'b1, NO_CUT, $urandom_range(0, 4) == 0);
        end else if (r < 80) begin
          send_frame(len, FILL_RANDOM, 1'b0, $urandom_range(1, LEN_OFFSET + len), 1'b0);
        end else if (r < 86 && limit < 255) begin
          send_frame($urandom_range(limit + 1, 255), FILL_RANDOM, 1'b0,
                     LEN_OFFSET + 1 + $urandom_range(0, 3), 1'b0);
        end else begin
          // line noise, usually closed by an end of transfer
          nb = $urandom_range(1, 6);
          for (int i = 0; i < nb; i++)
            send_byte(($urandom_range(0, 3) == 0) ? pdc_pkg::START_BYTE : 8'($urandom),
                      (i == nb - 1) && ($urandom_range(0, 9) < 6));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    errors       = 0;
    cycles       = 0;
    bytes_sent   = 0;
    n_data       = 0;
    n_ok         = 0;
    n_crc_err    = 0;
    n_incomplete = 0;
    idle_on      = 1'b1;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid           = 1'b0;
    in_ch.rx_byte         = '0;
    in_ch.end_of_transfer = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_payload_limits();
    test_random_stream();

    settle();
    repeat (8) @(negedge clk);
    $display("Sent %0d bytes over max_payload settings from 0 to 255; checked %0d data bytes,",
             bytes_sent, n_data);
    $display("%0d accepted frames, %0d checksum errors, %0d incomplete frames",
             n_ok, n_crc_err, n_incomplete);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== packet_deframer_crc16.f =====
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_in_if.sv
hw/rtl/pdc_out_if.sv
hw/rtl/pdc_res_queue.sv
hw/rtl/packet_deframer_crc16.sv
dv/tb_packet_deframer_crc16.sv
